>>> sv/bts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types and constants for the buzzer tone sweep generator.
// ----------------------------------------------------------------------------
package bts_pkg;

  // Item kinds carried on in_tuser
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_TONE  = 2'd1;
  localparam logic [1:0] KIND_SWEEP = 2'd2;

  localparam int unsigned FREQ_W = 16;
  localparam int unsigned DUR_W  = 8;
  localparam int unsigned HALF_W = 15;
  localparam int unsigned CNT_W  = 8;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [FREQ_W-1:0] FREQ_MAX     = 16'd30000;
  localparam logic [FREQ_W-1:0] FREQ_MIN     = 16'd10;
  localparam logic [FREQ_W-1:0] DIVIDEND     = 16'd40000;
  localparam logic [HALF_W-1:0] HALF_MAX     = 15'd20000;
  localparam logic [HALF_W-1:0] HALF_MIN     = 15'd10;
  localparam logic [CNT_W-1:0]  PERIODS_WRAP = 8'd255;

  // f / 100 == (f * 5243) >> 19 for every f up to 30000
  localparam logic [12:0] DIV100_MUL = 13'd5243;
  localparam int unsigned DIV100_SH  = 19;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_TONE  = 2'd1,
    MODE_SWEEP = 2'd2
  } mode_t;

  typedef struct packed {
    logic capture;    // latch accepted item
    logic exec;       // apply tick or command
    logic div_start;  // load divider and first multiply
    logic div_step;   // one quotient bit
    logic load;       // set up the new tone
    logic emit;       // load output register
  } bts_cmd_t;

  typedef struct packed {
    logic need_begin; // item starts a new tone
  } bts_sts_t;

endpackage

>>> sv/bts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_ctrl
// Sequencer: accept, execute, divide, tone setup and result hand-off.
// ----------------------------------------------------------------------------
module bts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  bts_pkg::bts_sts_t sts,
  output bts_pkg::bts_cmd_t cmd
);
  import bts_pkg::*;

  localparam int unsigned DIV_STEPS = FREQ_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIVI,
    S_DIV,
    S_LOAD,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_begin ? S_DIVI : S_DONE;
      end
      S_DIVI: begin
        cmd.div_start = 1'b1;
        step_nxt      = '0;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_EXEC))
    else $error("accepted item did not enter execute");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_tready))
    else $error("result overwrote an untaken result");

  a_load_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> ($past(state_r) == S_DIV))
    else $error("tone setup without a finished divide");

endmodule

>>> sv/bts_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_dp
// Datapath: tone/sweep state, tick counting, serial divider, period count.
// ----------------------------------------------------------------------------
module bts_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bts_pkg::bts_cmd_t                   cmd,
  output bts_pkg::bts_sts_t                   sts,
  input  logic [1:0]                          in_kind,
  input  logic [bts_pkg::FREQ_W-1:0]          in_first_freq,
  input  logic [bts_pkg::FREQ_W-1:0]          in_second_freq,
  input  logic [bts_pkg::DUR_W-1:0]           in_duration,
  output logic                                buzzer_level,
  output logic                                busy_res
);
  import bts_pkg::*;

  localparam int unsigned FC_W = 15;
  localparam int unsigned P1_W = FC_W + 13;
  localparam int unsigned Q_W  = P1_W - DIV100_SH;

  // captured item
  logic [1:0]        kind_r;
  logic [FREQ_W-1:0] f1_r, f2_r;
  logic [DUR_W-1:0]  dur_r;

  // tone state
  mode_t             mode_r, mode_nxt;
  logic [FREQ_W-1:0] cur_r, cur_nxt, tgt_r, tgt_nxt;
  logic [CNT_W-1:0]  tones_r, tones_nxt, per_r, per_nxt;
  logic [DUR_W-1:0]  fac_r, fac_nxt;
  logic [HALF_W-1:0] half_r, half_nxt, tick_r, tick_nxt;
  logic              pin_r, pin_nxt;

  // divide / multiply
  logic [FREQ_W-1:0] rem_r, quo_r;
  logic [FC_W-1:0]   fc_r;
  logic [DUR_W-1:0]  dc_r;
  logic [P1_W-1:0]   prod1_r;
  logic [CNT_W-1:0]  c_r;

  logic [1:0]        out_r;

  logic [FREQ_W-1:0] fc_w;
  logic [DUR_W-1:0]  dc_w;
  logic [FREQ_W-1:0] diff_w;
  logic [HALF_W-1:0] tick_inc;
  logic [CNT_W-1:0]  per_dec;
  logic              half_end, tone_end;
  logic [FREQ_W-1:0] trial;
  logic [Q_W-1:0]    q100;
  logic [Q_W:0]      dsum;
  logic [DUR_W+Q_W:0] prod2;
  logic [HALF_W-1:0] h_raw;

  always_comb begin
    if (cur_r > FREQ_MAX)      fc_w = FREQ_MAX;
    else if (cur_r < FREQ_MIN) fc_w = FREQ_MIN;
    else                       fc_w = cur_r;
    dc_w = (fac_r == '0) ? DUR_W'(1) : fac_r;
  end

  assign diff_w   = (f1_r > f2_r) ? (f1_r - f2_r) : (f2_r - f1_r);
  assign tick_inc = tick_r + 1'b1;
  assign per_dec  = per_r - 1'b1;
  assign half_end = (tick_inc >= half_r);
  assign tone_end = half_end && !pin_r && (per_dec == '0);

  always_comb begin
    unique case (kind_r)
      KIND_TICK:  sts.need_begin = (mode_r == MODE_SWEEP) && tone_end && (tones_r != '0);
      KIND_TONE:  sts.need_begin = (mode_r == MODE_IDLE);
      KIND_SWEEP: sts.need_begin = (mode_r == MODE_IDLE) && (diff_w[CNT_W-1:0] != '0);
      default:    sts.need_begin = 1'b0;
    endcase
  end

  // one restoring divide step; remainder stays below the 15-bit divisor
  assign trial = {rem_r[FREQ_W-2:0], quo_r[FREQ_W-1]};

  assign q100  = prod1_r[P1_W-1:DIV100_SH];
  assign dsum  = {{(Q_W+1-DUR_W){1'b0}}, dc_r} + {1'b0, q100};
  assign prod2 = dc_r * dsum;
  assign h_raw = quo_r[HALF_W:1];

  always_comb begin
    mode_nxt  = mode_r;
    cur_nxt   = cur_r;
    tgt_nxt   = tgt_r;
    tones_nxt = tones_r;
    fac_nxt   = fac_r;
    half_nxt  = half_r;
    per_nxt   = per_r;
    tick_nxt  = tick_r;
    pin_nxt   = pin_r;
    if (cmd.exec) begin
      unique case (kind_r)
        KIND_TICK: begin
          if (mode_r != MODE_IDLE) begin
            if (!half_end) begin
              tick_nxt = tick_inc;
            end else begin
              tick_nxt = '0;
              if (pin_r) begin
                pin_nxt = 1'b0;
              end else begin
                per_nxt = per_dec;
                if (per_dec != '0) begin
                  pin_nxt = 1'b1;
                end else if (mode_r == MODE_SWEEP && tones_r != '0) begin
                  cur_nxt   = (cur_r < tgt_r) ? cur_r + 1'b1 : cur_r - 1'b1;
                  tones_nxt = tones_r - 1'b1;
                end else begin
                  mode_nxt = MODE_IDLE;
                  pin_nxt  = 1'b0;
                end
              end
            end
          end
        end
        KIND_TONE: begin
          if (mode_r == MODE_IDLE) begin
            mode_nxt = MODE_TONE;
            cur_nxt  = f1_r;
            fac_nxt  = dur_r;
          end
        end
        KIND_SWEEP: begin
          if (mode_r == MODE_IDLE && diff_w[CNT_W-1:0] != '0) begin
            mode_nxt  = MODE_SWEEP;
            cur_nxt   = f1_r;
            tgt_nxt   = f2_r;
            fac_nxt   = dur_r;
            tones_nxt = diff_w[CNT_W-1:0] - 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (cmd.load) begin
      if (h_raw > HALF_MAX)      half_nxt = HALF_MAX;
      else if (h_raw < HALF_MIN) half_nxt = HALF_MIN;
      else                       half_nxt = h_raw;
      if (c_r == '0)             per_nxt = PERIODS_WRAP;
      else if (c_r == CNT_W'(1)) per_nxt = CNT_W'(1);
      else                       per_nxt = c_r - 1'b1;
      tick_nxt = '0;
      pin_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      cur_r   <= '0;
      tgt_r   <= '0;
      tones_r <= '0;
      fac_r   <= '0;
      half_r  <= '0;
      per_r   <= '0;
      tick_r  <= '0;
      pin_r   <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      cur_r   <= cur_nxt;
      tgt_r   <= tgt_nxt;
      tones_r <= tones_nxt;
      fac_r   <= fac_nxt;
      half_r  <= half_nxt;
      per_r   <= per_nxt;
      tick_r  <= tick_nxt;
      pin_r   <= pin_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      f1_r   <= in_first_freq;
      f2_r   <= in_second_freq;
      dur_r  <= in_duration;
    end
    if (cmd.div_start) begin
      rem_r   <= '0;
      quo_r   <= DIVIDEND;
      fc_r    <= fc_w[FC_W-1:0];
      dc_r    <= dc_w;
      prod1_r <= fc_w[FC_W-1:0] * DIV100_MUL;
    end
    if (cmd.div_step) begin
      if (trial >= {1'b0, fc_r}) begin
        rem_r <= trial - {1'b0, fc_r};
        quo_r <= {quo_r[FREQ_W-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        quo_r <= {quo_r[FREQ_W-2:0], 1'b0};
      end
      c_r <= prod2[CNT_W-1:0];
    end
    if (cmd.emit) begin
      out_r <= {mode_r != MODE_IDLE, pin_r};
    end
  end

  assign buzzer_level = out_r[0];
  assign busy_res     = out_r[1];

  a_half_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.load) |-> (half_r >= HALF_MIN && half_r <= HALF_MAX && pin_r))
    else $error("tone setup left half period out of range");

  a_idle_pin_low: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IDLE) |-> !pin_r)
    else $error("pin high while idle");

endmodule

>>> sv/buzzer_tone_sweep_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buzzer_tone_sweep_generator_core
// Square-wave buzzer driver: tone and sweep commands, microsecond ticks.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                   | tuser
//  in_     | in  | [15:0] first_freq [31:16] second_freq   | [1:0] kind
//          |     | [39:32] duration                        |
//  out_    | out | [0] buzzer_level [1] busy_res, rest 0   | -
//
//  A tick or an ignored command goes from accept through execute to result.
//  A command or tick that starts a tone also passes through the serial
//  divider for 40000 / f, which produces one quotient bit per cycle.
//  One item is in flight at a time; in_tready is high only when idle.
//  The result register holds its item until taken, and the next item is
//  accepted meanwhile; a stalled output then holds that next item too.
//  Synchronous active-low reset returns the block to idle with the pin low.
// ----------------------------------------------------------------------------
module buzzer_tone_sweep_generator_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bts_pkg::IN_DATA_W-1:0]    in_tdata,   // first_freq, second_freq, duration
  input  logic [1:0]                       in_tuser,   // kind
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bts_pkg::OUT_DATA_W-1:0]   out_tdata   // buzzer_level, busy_res, zero fill
);
  import bts_pkg::*;

  bts_cmd_t cmd;
  bts_sts_t sts;
  logic     level;
  logic     busy;

  bts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // item fields are unpacked straight from tdata, lowest field first
  bts_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_kind        (in_tuser),
    .in_first_freq  (in_tdata[FREQ_W-1:0]),
    .in_second_freq (in_tdata[2*FREQ_W-1:FREQ_W]),
    .in_duration    (in_tdata[2*FREQ_W+DUR_W-1:2*FREQ_W]),
    .buzzer_level   (level),
    .busy_res       (busy)
  );

  assign out_tdata = {{(OUT_DATA_W-2){1'b0}}, busy, level};

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the buzzer tone sweep generator. A queue of items
// (ticks, tones, sweeps, unused kinds) feeds a stream driver with random
// gaps. Each accepted item is run through a local pin and busy predictor, and
// the monitor compares every result against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import bts_pkg::*;

  localparam logic [1:0]  KIND_UNUSED   = 2'd3;
  localparam int unsigned F_TOP         = 30000;
  localparam int unsigned F_BOTTOM      = 10;
  localparam int unsigned TONE_DIVIDEND = 40000;
  localparam int unsigned HALF_TOP      = 20000;
  localparam int unsigned HALF_BOTTOM   = 10;
  localparam int unsigned SHORT_TICKS   = 100;   // longest tone the random part picks
  localparam int unsigned RANDOM_TICKS  = 200;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned TAIL_CYCLES   = 30;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  dur;
    logic [15:0] f2;
    logic [15:0] f1;
  } buzz_cmd_t;

  typedef struct packed {
    logic busy;
    logic level;
  } pin_state_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // first_freq, second_freq, duration
  logic [1:0]            in_tuser   = KIND_TICK;  // kind
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;  // buzzer_level, busy_res, zero fill

  buzzer_tone_sweep_generator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  buzz_cmd_t   pending_cmds[$];
  pin_state_t  expected_pins[$];
  buzz_cmd_t   on_bus;
  int unsigned cmds_queued;
  int unsigned cmds_taken;
  int unsigned results_taken;
  int unsigned err_count;
  int unsigned ticks_sent;
  int unsigned send_gap;
  int unsigned recv_wait;
  int unsigned hold_left;
  bit          no_gaps;

  // predicted buzzer state
  mode_t       st_mode       = MODE_IDLE;
  logic [15:0] st_cur        = '0;
  logic [15:0] st_target     = '0;
  logic [7:0]  st_tones_left = '0;
  logic [7:0]  st_factor     = '0;
  logic [7:0]  st_periods    = '0;
  logic [14:0] st_half       = '0;
  logic [14:0] st_ticks      = '0;
  logic        st_pin        = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned clamped_freq(logic [15:0] f);
    if (f > F_TOP) return F_TOP;
    if (f < F_BOTTOM) return F_BOTTOM;
    return f;
  endfunction

  function automatic logic [14:0] half_of(logic [15:0] f);
    int unsigned h;
    h = (TONE_DIVIDEND / clamped_freq(f)) / 2;
    if (h > HALF_TOP) h = HALF_TOP;
    if (h < HALF_BOTTOM) h = HALF_BOTTOM;
    return h[14:0];
  endfunction

  function automatic logic [7:0] period_code(logic [15:0] f, logic [7:0] dur);
    int unsigned d;
    d = (dur == 8'd0) ? 1 : dur;
    return 8'(d * (d + clamped_freq(f) / 100));
  endfunction

  // code 0 wraps to the longest tone, 1 and 2 both give a single period
  function automatic logic [7:0] periods_of(logic [7:0] code);
    if (code == 8'd0) return 8'd255;
    if (code == 8'd1) return 8'd1;
    return code - 8'd1;
  endfunction

  function automatic int unsigned tone_ticks(logic [15:0] f, logic [7:0] dur);
    return 2 * half_of(f) * periods_of(period_code(f, dur));
  endfunction

  function automatic logic [15:0] step_toward(logic [15:0] f, logic [15:0] stop);
    return (f < stop) ? f + 16'd1 : f - 16'd1;
  endfunction

  task automatic start_tone(logic [15:0] f, logic [7:0] dur);
    st_half    = half_of(f);
    st_periods = periods_of(period_code(f, dur));
    st_ticks   = '0;
    st_pin     = 1'b1;
  endtask

  task automatic advance_tick();
    if (st_mode == MODE_IDLE) return;
    st_ticks = st_ticks + 15'd1;
    if (st_ticks < st_half) return;
    st_ticks = '0;
    if (st_pin) begin
      st_pin = 1'b0;
      return;
    end
    st_periods = st_periods - 8'd1;
    if (st_periods != 8'd0) begin
      st_pin = 1'b1;
      return;
    end
    if (st_mode == MODE_SWEEP && st_tones_left != 8'd0) begin
      st_cur        = step_toward(st_cur, st_target);
      st_tones_left = st_tones_left - 8'd1;
      start_tone(st_cur, st_factor);
    end else begin
      st_mode = MODE_IDLE;
      st_pin  = 1'b0;
    end
  endtask

  // Applies one accepted item and queues the pin/busy result it must produce.
  task automatic advance_buzzer(buzz_cmd_t c);
    logic [15:0] span;
    unique case (c.kind)
      KIND_TICK: begin
        advance_tick();
      end
      KIND_TONE: begin
        if (st_mode == MODE_IDLE) begin
          st_mode   = MODE_TONE;
          st_cur    = c.f1;
          st_factor = c.dur;
          start_tone(c.f1, c.dur);
        end
      end
      KIND_SWEEP: begin
        if (st_mode == MODE_IDLE) begin
          span = (c.f1 > c.f2) ? c.f1 - c.f2 : c.f2 - c.f1;
          if (span[7:0] != 8'd0) begin
            st_mode       = MODE_SWEEP;
            st_cur        = c.f1;
            st_target     = c.f2;
            st_factor     = c.dur;
            st_tones_left = span[7:0] - 8'd1;
            start_tone(c.f1, c.dur);
          end
        end
      end
      default: begin
      end
    endcase
    expected_pins.push_back('{busy: (st_mode != MODE_IDLE), level: st_pin});
  endtask

  task automatic note_error(string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  // ---- stimulus helpers ----

  function automatic buzz_cmd_t make_cmd(logic [1:0] kind, logic [15:0] f1,
                                         logic [15:0] f2, logic [7:0] dur);
    buzz_cmd_t c;
    c.kind = kind;
    c.f1   = f1;
    c.f2   = f2;
    c.dur  = dur;
    return c;
  endfunction

  function automatic logic [15:0] any_freq();
    if ($urandom_range(0, 19) == 0) return 16'($urandom_range(1000, 1904));
    return 16'($urandom_range(1905, 65535));
  endfunction

  function automatic logic sweep_is_short(logic [15:0] f1, logic [15:0] f2,
                                          logic [7:0] dur, int unsigned tones);
    logic [15:0] f;
    f = f1;
    repeat (tones) begin
      if (tone_ticks(f, dur) > SHORT_TICKS) return 1'b0;
      f = step_toward(f, f2);
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] factor_for(logic [15:0] f, logic [7:0] code);
    for (int d = 0; d < 256; d++) begin
      if (period_code(f, 8'(d)) == code) return 8'(d);
    end
    return 8'd0;
  endfunction

  function automatic logic [7:0] sweep_factor(logic [15:0] f1, logic [15:0] f2);
    logic [15:0] span;
    span = (f1 > f2) ? f1 - f2 : f2 - f1;
    for (int d = 0; d < 256; d++) begin
      if (sweep_is_short(f1, f2, 8'(d), span[7:0])) return 8'(d);
    end
    return 8'd0;
  endfunction

  function automatic buzz_cmd_t short_tone();
    buzz_cmd_t   c;
    int unsigned tries;
    tries = 0;
    do begin
      c = make_cmd(KIND_TONE, any_freq(), 16'($urandom), 8'($urandom));
      tries++;
    end while (tone_ticks(c.f1, c.dur) > SHORT_TICKS && tries < 5000);
    return c;
  endfunction

  // Sweep whose tone count (distance mod 256) is exactly `tones`; the real
  // distance may be much larger.
  function automatic buzz_cmd_t short_sweep(int unsigned tones);
    buzz_cmd_t   c;
    int          stop;
    int          delta;
    int unsigned tries;
    tries = 0;
    do begin
      c = make_cmd(KIND_SWEEP, any_freq(), 16'd0, 8'($urandom));
      do begin
        delta = tones + 256 * $urandom_range(0, 255);
        stop  = $urandom_range(0, 1) ? int'(c.f1) + delta : int'(c.f1) - delta;
      end while (stop < 0 || stop > 65535);
      c.f2 = 16'(stop);
      tries++;
    end while (!sweep_is_short(c.f1, c.f2, c.dur, tones) && tries < 20000);
    return c;
  endfunction

  // Mostly ticks; commands here are normally ignored as the block is busy.
  function automatic buzz_cmd_t filler();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 88) return make_cmd(KIND_TICK, 16'($urandom), 16'($urandom), 8'($urandom));
    if (r < 94) return make_cmd(KIND_UNUSED, 16'($urandom), 16'($urandom), 8'($urandom));
    if (r < 97) return short_tone();
    return short_sweep($urandom_range(1, 3));
  endfunction

  task automatic push_cmd(buzz_cmd_t c);
    pending_cmds.push_back(c);
    cmds_queued++;
    if (c.kind == KIND_TICK) ticks_sent++;
  endtask

  task automatic settle();
    while (cmds_taken != cmds_queued) @(posedge clk);
  endtask

  task automatic drain();
    settle();
    while (expected_pins.size() != 0) @(posedge clk);
  endtask

  // Keeps feeding filler items, mostly ticks, until the predicted block has gone idle.
  task automatic play_out();
    int unsigned n;
    do begin
      n = $urandom_range(4, 24);
      repeat (n) push_cmd(filler());
      settle();
    end while (st_mode != MODE_IDLE);
  endtask

  task automatic run_cmd(buzz_cmd_t c);
    push_cmd(c);
    if ($urandom_range(0, 1) == 0) push_cmd($urandom_range(0, 1) ? short_tone() : short_sweep(2));
    play_out();
  endtask

  // ---- driver ----
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= KIND_TICK;
      send_gap  <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        advance_buzzer(on_bus);
        cmds_taken++;
      end
      if (in_tvalid && !in_tready) begin
        // hold the item until taken
      end else if (send_gap != 0) begin
        in_tvalid <= 1'b0;
        send_gap  <= send_gap - 1;
      end else if (pending_cmds.size() != 0) begin
        on_bus    = pending_cmds.pop_front();
        in_tdata  <= {on_bus.dur, on_bus.f2, on_bus.f1};
        in_tuser  <= on_bus.kind;
        in_tvalid <= 1'b1;
        send_gap  <= no_gaps ? 0 : $urandom_range(0, 5);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---- monitor and result-side flow control ----
  always @(posedge clk) begin : result_monitor
    pin_state_t  want;
    int unsigned w;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_wait  <= 0;
      hold_left  <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_taken++;
        if (expected_pins.size() == 0) begin
          note_error($sformatf("result %0d: no result expected, got %h",
                               results_taken, out_tdata));
        end else begin
          want = expected_pins.pop_front();
          if (out_tdata[0] !== want.level || out_tdata[1] !== want.busy)
            note_error($sformatf("result %0d: expected level %b busy %b, got level %b busy %b",
                                 results_taken, want.level, want.busy,
                                 out_tdata[0], out_tdata[1]));
        end
      end
      if (hold_left != 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (out_tvalid && out_tready && results_taken % 4000 == 120) begin
        // long stall so the block backs up into its input
        hold_left  <= LONG_HOLD;
        out_tready <= 1'b0;
      end else if (out_tvalid && out_tready) begin
        w          = no_gaps ? 0 : $urandom_range(0, 5);
        recv_wait  <= w;
        out_tready <= (w == 0);
      end else if (recv_wait != 0) begin
        recv_wait  <= recv_wait - 1;
        out_tready <= (recv_wait == 1);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---- stimulus ----
  initial begin : stimulus
    int unsigned r;
    int unsigned tick_mark;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // idle block: tick and unused kind do nothing
    push_cmd(make_cmd(KIND_TICK, 16'hFFFF, 16'hFFFF, 8'hFF));
    push_cmd(make_cmd(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF));
    push_cmd(make_cmd(KIND_UNUSED, 16'h0000, 16'h0000, 8'h00));
    // single period tone
    run_cmd(make_cmd(KIND_TONE, 16'd2400, 16'hFFFF, factor_for(16'd2400, 8'd1)));
    // zero duration counts as one; the period code wraps around to one period
    run_cmd(make_cmd(KIND_TONE, 16'd25600, 16'h0000, 8'd0));
    // frequency above range, clamped to the top rate
    run_cmd(make_cmd(KIND_TONE, 16'hFFFF, 16'h0000, factor_for(16'hFFFF, 8'd5)));
    // commands while busy are dropped
    push_cmd(short_tone());
    push_cmd(make_cmd(KIND_TONE, 16'd0, 16'd0, 8'd1));
    push_cmd(make_cmd(KIND_SWEEP, 16'd0, 16'hFFFF, 8'hFF));
    play_out();
    drain();
    // sweeps that play nothing: equal ends, distance a multiple of 256
    run_cmd(make_cmd(KIND_SWEEP, 16'd5000, 16'd5000, 8'd7));
    run_cmd(make_cmd(KIND_SWEEP, 16'd1000, 16'd1256, 8'd7));
    // sweeps up, down at the top of the range, and down across a /100 step
    run_cmd(make_cmd(KIND_SWEEP, 16'd2000, 16'd2002, sweep_factor(16'd2000, 16'd2002)));
    run_cmd(make_cmd(KIND_SWEEP, 16'hFFFF, 16'hFFFD, sweep_factor(16'hFFFF, 16'hFFFD)));
    run_cmd(make_cmd(KIND_SWEEP, 16'd200, 16'd198, 8'd1));
    drain();

    tick_mark = ticks_sent;
    while (ticks_sent - tick_mark < RANDOM_TICKS) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 9);
      if (r < 4) run_cmd(short_tone());
      else if (r < 8) run_cmd(short_sweep($urandom_range(1, 6)));
      else if (r == 8) run_cmd(short_sweep(0));
      else play_out();
      if ($urandom_range(0, 3) == 0) drain();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
